// ===== rtl/circle_elastic_collision_unit_defines.svh =====
// Assertion macros for the disc collision pipeline.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef CIRCLE_ELASTIC_COLLISION_UNIT_DEFINES_SVH
`define CIRCLE_ELASTIC_COLLISION_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define CED_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define CED_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CED_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define CED_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/ced_pkg.sv =====
// Constants, stage types and helper functions of the disc collision pipeline.
// No dependencies.
package ced_pkg;

   localparam int DIR_BITS  = 14;               // direction magnitude limit, bits
   localparam int MIX_BITS  = 28;               // fraction bits of the mass factors
   localparam int DIV_STEPS = 34;               // quotient bits of the divider
   localparam int NUM_W     = 67;               // divider numerator width
   localparam int SH_W      = 5;                // direction shift count width
   localparam int FA_W      = MIX_BITS + 2;     // mass factor width, holds 2^(MIX_BITS+1)
   localparam int U_W       = DIV_STEPS + 1;    // signed normal component width
   localparam int PROD_W    = U_W + FA_W + 1;   // signed product width
   localparam int T_W       = PROD_W - MIX_BITS;
   localparam int SUM_W     = T_W + 1;

   typedef logic [NUM_W-1:0] num_type;

   typedef struct packed {
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] bx;
      logic signed [31:0] by;
   } vel_type;

   typedef struct packed {
      vel_type            vel;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [32:0] dvx;
      logic signed [32:0] dvy;
      logic [31:0]        rsum;
      logic [31:0]        ma;
      logic [31:0]        mb;
   } s1_type;

   typedef struct packed {
      vel_type            vel;
      logic signed [32:0] dvx;
      logic signed [32:0] dvy;
      logic               sgx;
      logic               sgy;
      logic [31:0]        adx;
      logic [31:0]        ady;
      logic [31:0]        rsum;
      logic [32:0]        msum;
      logic [31:0]        mb;
      logic               pre;
   } s2_type;

   typedef struct packed {
      vel_type            vel;
      logic signed [32:0] dvx;
      logic signed [32:0] dvy;
      logic               sgx;
      logic               sgy;
      logic [31:0]        adx;
      logic [31:0]        ady;
      logic [63:0]        x2;
      logic [63:0]        y2;
      logic [63:0]        r2;
      logic [SH_W-1:0]    sh;
      logic [32:0]        msum;
      logic [31:0]        mb;
      logic               pre;
   } s3_type;

   typedef struct packed {
      vel_type                  vel;
      logic signed [32:0]       dvx;
      logic signed [32:0]       dvy;
      logic signed [DIR_BITS:0] ex;
      logic signed [DIR_BITS:0] ey;
      logic [32:0]              msum;
      logic [31:0]              mb;
      logic                     hit;
   } s4_type;

   typedef struct packed {
      vel_type                  vel;
      logic signed [47:0]       px;
      logic signed [47:0]       py;
      logic signed [DIR_BITS:0] ex;
      logic signed [DIR_BITS:0] ey;
      logic [29:0]              n2;
      logic [32:0]              msum;
      logic [31:0]              mb;
      logic                     hit;
   } s5_type;

   typedef struct packed {
      vel_type                  vel;
      logic signed [48:0]       p;
      logic signed [DIR_BITS:0] ex;
      logic signed [DIR_BITS:0] ey;
      logic [29:0]              n2;
      logic [32:0]              msum;
      logic [31:0]              mb;
      logic                     hit;
   } s6_type;

   typedef struct packed {
      vel_type            vel;
      logic signed [63:0] pex;
      logic signed [63:0] pey;
      logic [29:0]        n2;
      logic [32:0]        msum;
      logic [31:0]        mb;
      logic               hit;
   } s7_type;

   typedef struct packed {
      vel_type              vel;
      num_type              nx;
      num_type              ny;
      num_type              nm;
      logic [DIV_STEPS-1:0] qx;
      logic [DIV_STEPS-1:0] qy;
      logic [DIV_STEPS-1:0] qm;
      logic                 sx;
      logic                 sy;
      logic [29:0]          n2;
      logic [32:0]          msum;
      logic                 hit;
   } div_type;

   typedef struct packed {
      vel_type               vel;
      logic signed [U_W-1:0] ux;
      logic signed [U_W-1:0] uy;
      logic [FA_W-1:0]       fa;
      logic [FA_W-1:0]       fb;
      logic                  hit;
   } sa_type;

   typedef struct packed {
      vel_type                  vel;
      logic signed [PROD_W-1:0] pax;
      logic signed [PROD_W-1:0] pay;
      logic signed [PROD_W-1:0] pbx;
      logic signed [PROD_W-1:0] pby;
      logic                     hit;
   } sb_type;

   typedef struct packed {
      vel_type               vel;
      logic signed [T_W-1:0] tax;
      logic signed [T_W-1:0] tay;
      logic signed [T_W-1:0] tbx;
      logic signed [T_W-1:0] tby;
      logic                  hit;
   } sc_type;

   typedef struct packed {
      vel_type vel;
      logic    hit;
   } out_type;

   // Clamp to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
      if (v[SUM_W-1:31] == '0 || v[SUM_W-1:31] == '1) begin
         sat32 = v[31:0];
      end else if (v[SUM_W-1]) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = 32'sh7fff_ffff;
      end
   endfunction

   // Divide by 2^MIX_BITS, rounding toward zero.
   function automatic logic signed [T_W-1:0] trunc_mix(input logic signed [PROD_W-1:0] v);
      logic [PROD_W-1:0] biased;
      biased = v + {{(PROD_W-MIX_BITS){1'b0}}, {MIX_BITS{v[PROD_W-1]}}};
      trunc_mix = $signed(biased[PROD_W-1:MIX_BITS]);
   endfunction

endpackage

// ===== rtl/circle_elastic_collision_unit.sv =====
// An accepted req item passes through stages 1 to 7, the divider, A, B, C and the output stage.
// Throughput: one disc pair per cycle while rsp_stall is low; every stage has its own valid bit and
// loads whenever it is empty or the stage after it moves, so bubbles close up.
// The long part is the restoring divider, one quotient bit per stage (34 stages).
// Reset (synchronous, active high) clears the valid bits only.
// Disc pair elastic collision pipeline; uses ced_pkg and the assertion header.
`include "circle_elastic_collision_unit_defines.svh"

module circle_elastic_collision_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_a_pos_x,
   input  logic signed [31:0] req_a_pos_y,
   input  logic signed [31:0] req_a_vel_x,
   input  logic signed [31:0] req_a_vel_y,
   input  logic [30:0]        req_a_rad,
   input  logic [31:0]        req_a_mass,
   input  logic signed [31:0] req_b_pos_x,
   input  logic signed [31:0] req_b_pos_y,
   input  logic signed [31:0] req_b_vel_x,
   input  logic signed [31:0] req_b_vel_y,
   input  logic [30:0]        req_b_rad,
   input  logic [31:0]        req_b_mass,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic signed [31:0] rsp_a_new_vel_x,
   output logic signed [31:0] rsp_a_new_vel_y,
   output logic signed [31:0] rsp_b_new_vel_x,
   output logic signed [31:0] rsp_b_new_vel_y
);
   import ced_pkg::*;

   // Stage map: seven front stages, the divider, three back stages, output.
   localparam int ST_S4       = 3;
   localparam int ST_DIV0     = 7;
   localparam int ST_DIV_LAST = ST_DIV0 + DIV_STEPS - 1;
   localparam int ST_A        = ST_DIV_LAST + 1;
   localparam int ST_C        = ST_A + 2;
   localparam int ST_OUT      = ST_C + 1;
   localparam int NSTAGE      = ST_OUT + 1;

   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE-1:0] valid_in;
   logic [NSTAGE-1:0] ready;

   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   s3_type  s3_ff, s3_in;
   s4_type  s4_ff, s4_in;
   s5_type  s5_ff, s5_in;
   s6_type  s6_ff, s6_in;
   s7_type  s7_ff, s7_in;
   div_type div_seed;
   div_type div_ff [DIV_STEPS];
   sa_type  sa_ff, sa_in;
   sb_type  sb_ff, sb_in;
   sc_type  sc_ff, sc_in;
   out_type out_ff, out_in;

   // ---------------------------------------------------------------------
   // Flow control: a stage may load when it is empty or its successor moves.
   // ---------------------------------------------------------------------
   always_comb begin
      ready[NSTAGE-1] = !valid_ff[NSTAGE-1] || !rsp_stall;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   assign valid_in  = {valid_ff[NSTAGE-2:0], req_valid};
   assign req_stall = !ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NSTAGE; k++) begin
            if (ready[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: centre difference, velocity difference, radius sum.
   // ---------------------------------------------------------------------
   always_comb begin
      s1_in.vel.ax = req_a_vel_x;
      s1_in.vel.ay = req_a_vel_y;
      s1_in.vel.bx = req_b_vel_x;
      s1_in.vel.by = req_b_vel_y;
      s1_in.dx     = 33'(req_b_pos_x) - 33'(req_a_pos_x);
      s1_in.dy     = 33'(req_b_pos_y) - 33'(req_a_pos_y);
      s1_in.dvx    = 33'(req_a_vel_x) - 33'(req_b_vel_x);
      s1_in.dvy    = 33'(req_a_vel_y) - 33'(req_b_vel_y);
      s1_in.rsum   = {1'b0, req_a_rad} + {1'b0, req_b_rad};
      s1_in.ma     = req_a_mass;
      s1_in.mb     = req_b_mass;
   end

   // ---------------------------------------------------------------------
   // Stage 2: magnitudes, coarse range test, mass sum.
   // ---------------------------------------------------------------------
   always_comb begin
      logic [32:0] adx, ady;
      adx = s1_ff.dx[32] ? 33'(-s1_ff.dx) : 33'(s1_ff.dx);
      ady = s1_ff.dy[32] ? 33'(-s1_ff.dy) : 33'(s1_ff.dy);
      s2_in.vel  = s1_ff.vel;
      s2_in.dvx  = s1_ff.dvx;
      s2_in.dvy  = s1_ff.dvy;
      s2_in.sgx  = s1_ff.dx[32];
      s2_in.sgy  = s1_ff.dy[32];
      s2_in.adx  = adx[31:0];
      s2_in.ady  = ady[31:0];
      s2_in.rsum = s1_ff.rsum;
      s2_in.msum = {1'b0, s1_ff.ma} + {1'b0, s1_ff.mb};
      s2_in.mb   = s1_ff.mb;
      // Coincident centres never count as a hit.
      s2_in.pre  = ((adx | ady) != '0) && (adx <= {1'b0, s1_ff.rsum})
                   && (ady <= {1'b0, s1_ff.rsum});
   end

   // ---------------------------------------------------------------------
   // Stage 3: squares for the exact hit test, leading one for the direction.
   // ---------------------------------------------------------------------
   always_comb begin
      logic [31:0] orv;
      logic [4:0]  pos;
      orv = s2_ff.adx | s2_ff.ady;
      pos = '0;
      for (int i = 0; i < 32; i++) begin
         if (orv[i]) begin
            pos = 5'(i);
         end
      end
      s3_in.vel  = s2_ff.vel;
      s3_in.dvx  = s2_ff.dvx;
      s3_in.dvy  = s2_ff.dvy;
      s3_in.sgx  = s2_ff.sgx;
      s3_in.sgy  = s2_ff.sgy;
      s3_in.adx  = s2_ff.adx;
      s3_in.ady  = s2_ff.ady;
      s3_in.x2   = s2_ff.adx * s2_ff.adx;
      s3_in.y2   = s2_ff.ady * s2_ff.ady;
      s3_in.r2   = s2_ff.rsum * s2_ff.rsum;
      s3_in.sh   = (pos >= 5'(DIR_BITS)) ? SH_W'(pos - 5'(DIR_BITS - 1)) : '0;
      s3_in.msum = s2_ff.msum;
      s3_in.mb   = s2_ff.mb;
      s3_in.pre  = s2_ff.pre;
   end

   // ---------------------------------------------------------------------
   // Stage 4: final hit decision; scale the normal into DIR_BITS.
   // ---------------------------------------------------------------------
   always_comb begin
      logic [31:0] sx, sy;
      sx = s3_ff.adx >> s3_ff.sh;
      sy = s3_ff.ady >> s3_ff.sh;
      s4_in.vel  = s3_ff.vel;
      s4_in.dvx  = s3_ff.dvx;
      s4_in.dvy  = s3_ff.dvy;
      s4_in.ex   = s3_ff.sgx ? -$signed({1'b0, sx[DIR_BITS-1:0]})
                             :  $signed({1'b0, sx[DIR_BITS-1:0]});
      s4_in.ey   = s3_ff.sgy ? -$signed({1'b0, sy[DIR_BITS-1:0]})
                             :  $signed({1'b0, sy[DIR_BITS-1:0]});
      s4_in.msum = s3_ff.msum;
      s4_in.mb   = s3_ff.mb;
      s4_in.hit  = s3_ff.pre
                   && ({1'b0, s3_ff.x2} + {1'b0, s3_ff.y2} <= {1'b0, s3_ff.r2});
   end

   // ---------------------------------------------------------------------
   // Stage 5: projection products and normal length squared.
   // ---------------------------------------------------------------------
   always_comb begin
      logic signed [29:0] exx, eyy;
      exx = s4_ff.ex * s4_ff.ex;
      eyy = s4_ff.ey * s4_ff.ey;
      s5_in.vel  = s4_ff.vel;
      s5_in.px   = s4_ff.dvx * s4_ff.ex;
      s5_in.py   = s4_ff.dvy * s4_ff.ey;
      s5_in.ex   = s4_ff.ex;
      s5_in.ey   = s4_ff.ey;
      s5_in.n2   = {1'b0, exx[28:0]} + {1'b0, eyy[28:0]};
      s5_in.msum = s4_ff.msum;
      s5_in.mb   = s4_ff.mb;
      s5_in.hit  = s4_ff.hit;
   end

   // Stage 6: dot product.
   always_comb begin
      s6_in.vel  = s5_ff.vel;
      s6_in.p    = 49'(s5_ff.px) + 49'(s5_ff.py);
      s6_in.ex   = s5_ff.ex;
      s6_in.ey   = s5_ff.ey;
      s6_in.n2   = s5_ff.n2;
      s6_in.msum = s5_ff.msum;
      s6_in.mb   = s5_ff.mb;
      s6_in.hit  = s5_ff.hit;
   end

   // Stage 7: scale the direction by the dot product.
   always_comb begin
      s7_in.vel  = s6_ff.vel;
      s7_in.pex  = s6_ff.p * s6_ff.ex;
      s7_in.pey  = s6_ff.p * s6_ff.ey;
      s7_in.n2   = s6_ff.n2;
      s7_in.msum = s6_ff.msum;
      s7_in.mb   = s6_ff.mb;
      s7_in.hit  = s6_ff.hit;
   end

   always_ff @(posedge clock) begin
      if (ready[0]) s1_ff <= s1_in;
      if (ready[1]) s2_ff <= s2_in;
      if (ready[2]) s3_ff <= s3_in;
      if (ready[ST_S4]) s4_ff <= s4_in;
      if (ready[4]) s5_ff <= s5_in;
      if (ready[5]) s6_ff <= s6_in;
      if (ready[6]) s7_ff <= s7_in;
   end

   // ---------------------------------------------------------------------
   // Divider: sign-magnitude restoring division, one quotient bit per stage.
   // Three lanes share the stage: both normal components by the normal
   // length squared, and the mass factor 2*mB/(mA+mB).
   // ---------------------------------------------------------------------
   always_comb begin
      logic [63:0] mx, my;
      mx = s7_ff.pex[63] ? 64'(-s7_ff.pex) : 64'(s7_ff.pex);
      my = s7_ff.pey[63] ? 64'(-s7_ff.pey) : 64'(s7_ff.pey);
      div_seed.vel  = s7_ff.vel;
      div_seed.nx   = NUM_W'(mx);
      div_seed.ny   = NUM_W'(my);
      div_seed.nm   = NUM_W'(s7_ff.mb) << (MIX_BITS + 1);
      div_seed.qx   = '0;
      div_seed.qy   = '0;
      div_seed.qm   = '0;
      div_seed.sx   = s7_ff.pex[63];
      div_seed.sy   = s7_ff.pey[63];
      div_seed.n2   = s7_ff.n2;
      div_seed.msum = s7_ff.msum;
      div_seed.hit  = s7_ff.hit;
   end

   for (genvar gi = 0; gi < DIV_STEPS; gi++) begin : g_div
      localparam int QBIT = DIV_STEPS - 1 - gi;
      div_type src, nxt;

      if (gi == 0) begin : g_first
         assign src = div_seed;
      end else begin : g_next
         assign src = div_ff[gi-1];
      end

      always_comb begin
         num_type den_u, den_m;
         den_u = num_type'(src.n2) << QBIT;
         den_m = num_type'(src.msum) << QBIT;
         nxt = src;
         if (src.nx >= den_u) begin
            nxt.nx       = src.nx - den_u;
            nxt.qx[QBIT] = 1'b1;
         end
         if (src.ny >= den_u) begin
            nxt.ny       = src.ny - den_u;
            nxt.qy[QBIT] = 1'b1;
         end
         if (src.nm >= den_m) begin
            nxt.nm       = src.nm - den_m;
            nxt.qm[QBIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (ready[ST_DIV0 + gi]) div_ff[gi] <= nxt;
      end
   end

   // ---------------------------------------------------------------------
   // Stage A: restore signs; derive the second mass factor from the first.
   // floor(mA*K/S) = K - floor(mB*K/S) - (remainder != 0).
   // ---------------------------------------------------------------------
   always_comb begin
      div_type d;
      logic    rem_nz;
      d      = div_ff[DIV_STEPS-1];
      rem_nz = (d.nm != '0);
      sa_in.vel = d.vel;
      sa_in.ux  = d.sx ? -$signed({1'b0, d.qx}) : $signed({1'b0, d.qx});
      sa_in.uy  = d.sy ? -$signed({1'b0, d.qy}) : $signed({1'b0, d.qy});
      sa_in.hit = d.hit;
      if (d.msum == '0) begin
         // Both masses zero: treat as equal masses.
         sa_in.fa = FA_W'(1) << MIX_BITS;
         sa_in.fb = FA_W'(1) << MIX_BITS;
      end else begin
         sa_in.fa = d.qm[FA_W-1:0];
         sa_in.fb = (FA_W'(1) << (MIX_BITS + 1)) - d.qm[FA_W-1:0] - FA_W'(rem_nz);
      end
   end

   // Stage B: apply the mass factors.
   always_comb begin
      sb_in.vel = sa_ff.vel;
      sb_in.pax = sa_ff.ux * $signed({1'b0, sa_ff.fa});
      sb_in.pay = sa_ff.uy * $signed({1'b0, sa_ff.fa});
      sb_in.pbx = sa_ff.ux * $signed({1'b0, sa_ff.fb});
      sb_in.pby = sa_ff.uy * $signed({1'b0, sa_ff.fb});
      sb_in.hit = sa_ff.hit;
   end

   // Stage C: drop the factor fraction, rounding toward zero.
   always_comb begin
      sc_in.vel = sb_ff.vel;
      sc_in.tax = trunc_mix(sb_ff.pax);
      sc_in.tay = trunc_mix(sb_ff.pay);
      sc_in.tbx = trunc_mix(sb_ff.pbx);
      sc_in.tby = trunc_mix(sb_ff.pby);
      sc_in.hit = sb_ff.hit;
   end

   // Output stage: update and saturate, or pass the velocities through.
   always_comb begin
      out_in.hit = sc_ff.hit;
      out_in.vel = sc_ff.vel;
      if (sc_ff.hit) begin
         out_in.vel.ax = sat32(SUM_W'(sc_ff.vel.ax) - SUM_W'(sc_ff.tax));
         out_in.vel.ay = sat32(SUM_W'(sc_ff.vel.ay) - SUM_W'(sc_ff.tay));
         out_in.vel.bx = sat32(SUM_W'(sc_ff.vel.bx) + SUM_W'(sc_ff.tbx));
         out_in.vel.by = sat32(SUM_W'(sc_ff.vel.by) + SUM_W'(sc_ff.tby));
      end
   end

   always_ff @(posedge clock) begin
      if (ready[ST_A]) sa_ff <= sa_in;
      if (ready[ST_A + 1]) sb_ff <= sb_in;
      if (ready[ST_C]) sc_ff <= sc_in;
      if (ready[ST_OUT]) out_ff <= out_in;
   end

   assign rsp_valid       = valid_ff[ST_OUT];
   assign rsp_hit         = out_ff.hit;
   assign rsp_a_new_vel_x = out_ff.vel.ax;
   assign rsp_a_new_vel_y = out_ff.vel.ay;
   assign rsp_b_new_vel_x = out_ff.vel.bx;
   assign rsp_b_new_vel_y = out_ff.vel.by;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   // Input back-pressure only when the whole pipe is full and the output waits.
   `CED_ASSERT_IMPL(a_stall_full, clock, reset, req_stall, rsp_valid && rsp_stall, "req stalled with room in the pipe")
   // A hit always leaves a nonzero direction after scaling.
   `CED_ASSERT_IMPL(a_dir_nonzero, clock, reset, valid_ff[ST_S4] && s4_ff.hit, s4_ff.ex != '0 || s4_ff.ey != '0, "zero direction on a hit")
   // On a hit, both normal-lane divider remainders end below the normal length squared.
   `CED_ASSERT_IMPL(a_div_rem, clock, reset, valid_ff[ST_DIV_LAST] && div_ff[DIV_STEPS-1].hit, div_ff[DIV_STEPS-1].nx < NUM_W'(div_ff[DIV_STEPS-1].n2) && div_ff[DIV_STEPS-1].ny < NUM_W'(div_ff[DIV_STEPS-1].n2), "divider remainder out of range")
   // A finished item moving out of stage C shows up on the result channel.
   `CED_ASSERT_NEXT(a_out_load, clock, reset, valid_ff[ST_C] && ready[ST_OUT], rsp_valid, "item lost before the output register")

endmodule
